// ----- rtl/epbc_pkg.sv -----
// epbc_pkg: shared stage types, constants and helper functions of the calendar pipeline
`default_nettype none
package epbc_pkg;

    localparam logic [0:0] REG_TIMEZONE = 1'b0;
    localparam logic [0:0] REG_DST      = 1'b1;

    localparam logic signed [34:0] EPOCH_2000   = 35'sd946684800;
    localparam logic signed [34:0] SECS_HOUR    = 35'sd3600;
    localparam logic signed [34:0] SECS_CENTURY = 35'sd3155760000;

    // floor(2^32 / d), so the estimate is exact or one low for any 32-bit dividend; RECIP_QUAD is rounded up instead
    localparam logic [31:0] RECIP_DAY  = 32'd49710;
    localparam logic [31:0] RECIP_HOUR = 32'd1193046;
    localparam logic [31:0] RECIP_MIN  = 32'd71582788;
    localparam logic [31:0] RECIP_WEEK = 32'd613566756;
    localparam logic [31:0] RECIP_QUAD = 32'd2939745;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [31:0] t;
    } st1_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [31:0] t;
        logic [15:0] dq;
    } st2_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [15:0] days;
        logic [16:0] sod;
    } st3_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [16:0] sod;
        logic [4:0]  hq;
        logic [15:0] dp6;
        logic [12:0] wq;
        logic [15:0] days;
        logic [4:0]  cq;
    } st4_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [4:0]  hh;
        logic [11:0] remh;
        logic [2:0]  wd;
        logic [4:0]  c4;
        logic [10:0] r4;
    } st5_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [4:0]  hh;
        logic [11:0] remh;
        logic [5:0]  mq;
        logic [2:0]  wd;
        logic [6:0]  yr;
        logic [8:0]  doy;
        logic        leap;
    } st6_t;

    typedef struct packed {
        logic        vld;
        logic        oor;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [2:0]  wd;
        logic [6:0]  yr;
        logic [3:0]  mo;
        logic [4:0]  dom;
    } st7_t;

    // upper word of x * recip, a quotient estimate
    function automatic logic [31:0] div_est(input logic [31:0] x, input logic [31:0] recip);
        logic [63:0] p;
        p = 64'(x) * 64'(recip);
        return p[63:32];
    endfunction

    // first day of month (0-based) within the year
    function automatic logic [8:0] month_start(input logic [3:0] mo, input logic leap);
        logic [8:0] base;
        unique case (mo)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (mo >= 4'd2)) ? 1 : 0);
    endfunction

    // two bcd digits of a value below 100
    function automatic logic [7:0] bcd8(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        return {tens, 4'(v - 7'(tens) * 7'd10)};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/epbc_offset.sv -----
// epbc_offset: local time offset from 2000 and the century range check
`default_nettype none
module epbc_offset (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [31:0]       unix_seconds,
    input  wire logic signed [4:0] tz_hours,
    input  wire logic              dst_on,
    output epbc_pkg::st1_t         s1_o
);

    logic signed [5:0]  hours_off;
    logic signed [34:0] off_secs;
    logic signed [34:0] t_loc;
    epbc_pkg::st1_t     s1_reg, s1_next;

    assign hours_off = 6'(tz_hours) + $signed({5'b00000, dst_on});
    assign off_secs  = 35'(hours_off) * epbc_pkg::SECS_HOUR;
    assign t_loc     = $signed({3'b000, unix_seconds}) - epbc_pkg::EPOCH_2000 + off_secs;

    always_comb begin
        s1_next.vld = in_vld;
        s1_next.oor = t_loc[34] || (t_loc >= epbc_pkg::SECS_CENTURY);
        s1_next.t   = t_loc[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
        end else if (en) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_o = s1_reg;

endmodule
`default_nettype wire

// ----- rtl/epbc_daysplit.sv -----
// epbc_daysplit: splits local seconds into whole days and seconds of the day
`default_nettype none
module epbc_daysplit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire epbc_pkg::st1_t s1_i,
    output epbc_pkg::st3_t      s3_o
);

    epbc_pkg::st2_t s2_reg, s2_next;
    epbc_pkg::st3_t s3_reg, s3_next;
    logic [31:0]    r32;
    logic [17:0]    rem;

    always_comb begin
        s2_next.vld = s1_i.vld;
        s2_next.oor = s1_i.oor;
        s2_next.t   = s1_i.t;
        s2_next.dq  = 16'(epbc_pkg::div_est(s1_i.t, epbc_pkg::RECIP_DAY));
    end

    // estimate may be one day short
    assign r32 = s2_reg.t - 32'(s2_reg.dq) * 32'd86400;
    assign rem = r32[17:0];

    always_comb begin
        s3_next.vld = s2_reg.vld;
        s3_next.oor = s2_reg.oor;
        if (rem >= 18'd86400) begin
            s3_next.days = s2_reg.dq + 16'd1;
            s3_next.sod  = 17'(rem - 18'd86400);
        end else begin
            s3_next.days = s2_reg.dq;
            s3_next.sod  = rem[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.vld <= 1'b0;
            s3_reg.vld <= 1'b0;
        end else if (en) begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign s3_o = s3_reg;

endmodule
`default_nettype wire

// ----- rtl/epbc_fields.sv -----
// epbc_fields: hour, minute, second, weekday, year, month and day of month stages
`default_nettype none
module epbc_fields (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire epbc_pkg::st3_t s3_i,
    output epbc_pkg::st7_t      s7_o
);

    epbc_pkg::st4_t s4_reg, s4_next;
    epbc_pkg::st5_t s5_reg, s5_next;
    epbc_pkg::st6_t s6_reg, s6_next;
    epbc_pkg::st7_t s7_reg, s7_next;

    logic [16:0] remh0;
    logic [15:0] wr0;
    logic [15:0] qr0;
    logic [11:0] ss0;
    logic [3:0]  mo_sel;
    logic [8:0]  mo_base;

    // stage 4: quotient estimates for hour, week and four-year cycle
    always_comb begin
        s4_next.vld  = s3_i.vld;
        s4_next.oor  = s3_i.oor;
        s4_next.sod  = s3_i.sod;
        s4_next.hq   = 5'(epbc_pkg::div_est(32'(s3_i.sod), epbc_pkg::RECIP_HOUR));
        s4_next.dp6  = s3_i.days + 16'd6;
        s4_next.wq   = 13'(epbc_pkg::div_est(32'(s3_i.days + 16'd6),
                                             epbc_pkg::RECIP_WEEK));
        s4_next.days = s3_i.days;
        s4_next.cq   = 5'(epbc_pkg::div_est(32'(s3_i.days), epbc_pkg::RECIP_QUAD));
    end

    // stage 5: remainders with one correction step each
    assign remh0 = s4_reg.sod - 17'(s4_reg.hq) * 17'd3600;
    assign wr0   = s4_reg.dp6 - 16'(s4_reg.wq) * 16'd7;
    assign qr0   = s4_reg.days - 16'(s4_reg.cq) * 16'd1461;

    always_comb begin
        s5_next.vld = s4_reg.vld;
        s5_next.oor = s4_reg.oor;
        if (remh0 >= 17'd3600) begin
            s5_next.hh   = s4_reg.hq + 5'd1;
            s5_next.remh = 12'(remh0 - 17'd3600);
        end else begin
            s5_next.hh   = s4_reg.hq;
            s5_next.remh = remh0[11:0];
        end
        if (wr0 >= 16'd7) begin
            s5_next.wd = 3'(wr0 - 16'd7);
        end else begin
            s5_next.wd = wr0[2:0];
        end
        if (qr0 >= 16'd1461) begin
            s5_next.c4 = s4_reg.cq + 5'd1;
            s5_next.r4 = 11'(qr0 - 16'd1461);
        end else begin
            s5_next.c4 = s4_reg.cq;
            s5_next.r4 = qr0[10:0];
        end
    end

    // stage 6: year within the cycle (first year is leap), minute estimate
    always_comb begin
        s6_next.vld  = s5_reg.vld;
        s6_next.oor  = s5_reg.oor;
        s6_next.hh   = s5_reg.hh;
        s6_next.remh = s5_reg.remh;
        s6_next.mq   = 6'(epbc_pkg::div_est(32'(s5_reg.remh), epbc_pkg::RECIP_MIN));
        s6_next.wd   = s5_reg.wd;
        priority if (s5_reg.r4 < 11'd366) begin
            s6_next.yr   = {s5_reg.c4, 2'd0};
            s6_next.doy  = s5_reg.r4[8:0];
            s6_next.leap = 1'b1;
        end else if (s5_reg.r4 < 11'd731) begin
            s6_next.yr   = {s5_reg.c4, 2'd1};
            s6_next.doy  = 9'(s5_reg.r4 - 11'd366);
            s6_next.leap = 1'b0;
        end else if (s5_reg.r4 < 11'd1096) begin
            s6_next.yr   = {s5_reg.c4, 2'd2};
            s6_next.doy  = 9'(s5_reg.r4 - 11'd731);
            s6_next.leap = 1'b0;
        end else begin
            s6_next.yr   = {s5_reg.c4, 2'd3};
            s6_next.doy  = 9'(s5_reg.r4 - 11'd1096);
            s6_next.leap = 1'b0;
        end
    end

    // stage 7: minutes and seconds, month by parallel compares, day of month
    assign ss0 = s6_reg.remh - 12'(s6_reg.mq) * 12'd60;

    always_comb begin
        mo_sel = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (s6_reg.doy >= epbc_pkg::month_start(4'(m), s6_reg.leap)) begin
                mo_sel = 4'(m);
            end
        end
    end

    assign mo_base = epbc_pkg::month_start(mo_sel, s6_reg.leap);

    always_comb begin
        s7_next.vld = s6_reg.vld;
        s7_next.oor = s6_reg.oor;
        s7_next.hh  = s6_reg.hh;
        if (ss0 >= 12'd60) begin
            s7_next.mm = s6_reg.mq + 6'd1;
            s7_next.ss = 6'(ss0 - 12'd60);
        end else begin
            s7_next.mm = s6_reg.mq;
            s7_next.ss = ss0[5:0];
        end
        s7_next.wd  = s6_reg.wd;
        s7_next.yr  = s6_reg.yr;
        s7_next.mo  = mo_sel;
        s7_next.dom = 5'(s6_reg.doy - mo_base) + 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_reg.vld <= 1'b0;
            s5_reg.vld <= 1'b0;
            s6_reg.vld <= 1'b0;
            s7_reg.vld <= 1'b0;
        end else if (en) begin
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    assign s7_o = s7_reg;

endmodule
`default_nettype wire

// ----- rtl/epoch_to_bcd_calendar_top.sv -----
// epoch_to_bcd_calendar_top: unix seconds to bcd calendar words, top level
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: unix_seconds
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: calendar, tuser: out_of_range
//   cfg       in         cfg_wr_en                      cfg_addr, cfg_wdata
//
// one item per cycle while the output is not stalled; an item enters the first of 8 register
// stages at its accepting edge and passes through stages s1 to s7 into the output register,
// where its result can be taken.
// aresetn clears all valid bits, timezone to 0 and daylight saving to on.
// the whole pipeline holds while a result waits at the output; s_axis_tready
// drops in exactly those cycles.
`default_nettype none
module epoch_to_bcd_calendar_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
    output wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] seconds_bcd, [13:7] minutes_bcd, [19:14] hours_bcd, [25:20] day_bcd,
    // [28:26] weekday, [33:29] month_bcd, [41:34] year_bcd, [47:42] zero
    output wire logic [47:0] m_axis_tdata,
    output wire logic        m_axis_tuser,   // [0] out_of_range
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [4:0]  cfg_wdata
);

    logic signed [4:0] tz_reg;
    logic              dst_reg;
    logic              en;
    logic              m_valid_reg;
    logic [47:0]       m_data_reg, m_data_next;
    logic              m_user_reg;
    epbc_pkg::st1_t    s1;
    epbc_pkg::st3_t    s3;
    epbc_pkg::st7_t    s7;
    logic [7:0]        sec_b, min_b, hr_b, day_b, mon_b, yr_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tz_reg  <= 5'sd0;
            dst_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                epbc_pkg::REG_TIMEZONE: tz_reg  <= $signed(cfg_wdata);
                epbc_pkg::REG_DST:      dst_reg <= cfg_wdata[0];
                default:                ;
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being drained
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    epbc_offset u_offset (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_vld       (s_axis_tvalid),
        .unix_seconds (s_axis_tdata),
        .tz_hours     (tz_reg),
        .dst_on       (dst_reg),
        .s1_o         (s1)
    );

    epbc_daysplit u_daysplit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s1_i    (s1),
        .s3_o    (s3)
    );

    epbc_fields u_fields (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s3_i    (s3),
        .s7_o    (s7)
    );

    assign sec_b = epbc_pkg::bcd8(7'(s7.ss));
    assign min_b = epbc_pkg::bcd8(7'(s7.mm));
    assign hr_b  = epbc_pkg::bcd8(7'(s7.hh));
    assign day_b = epbc_pkg::bcd8(7'(s7.dom));
    assign mon_b = epbc_pkg::bcd8(7'(s7.mo) + 7'd1);
    assign yr_b  = epbc_pkg::bcd8(s7.yr);

    always_comb begin
        if (s7.oor) begin
            m_data_next = '0;
        end else begin
            m_data_next = {6'b000000, yr_b, mon_b[4:0], s7.wd, day_b[5:0],
                           hr_b[5:0], min_b[6:0], sec_b[6:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s7.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= s7.oor;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // out-of-range items carry all-zero calendar words
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 48'd0))
        else $error("out-of-range item with nonzero fields");

    // quotient corrections keep seconds and minutes in 00-59 and the hour tens digit at most 2
    a_time_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[6:4] <= 3'd5 && m_axis_tdata[3:0] <= 4'd9 &&
             m_axis_tdata[13:11] <= 3'd5 && m_axis_tdata[10:7] <= 4'd9 &&
             m_axis_tdata[19:18] <= 2'd2))
        else $error("time digits out of range");

    // day and month of an in-range item are never zero, weekday is never 7, unused bits stay zero
    a_date_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[25:20] != 6'd0 && m_axis_tdata[28:26] != 3'd7 &&
             m_axis_tdata[33:29] != 5'd0 && m_axis_tdata[47:42] == 6'd0))
        else $error("calendar fields out of range");

endmodule
`default_nettype wire
